### rtl/core/bba_pkg.sv
// shared types and constants of the buddy block allocator
`timescale 1ns / 1ps

package bba_pkg;

    // pool geometry
    localparam int MAX_ORDER  = 6;
    localparam int POOL_UNITS = 1 << MAX_ORDER;
    localparam int ADDR_W     = $clog2(POOL_UNITS);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int ORDER_W    = 3;
    localparam int NAME_W     = 16;
    localparam int SIZE_W     = 7;

    localparam logic [ORDER_W-1:0] TOTAL_ORDER_RESET = ORDER_W'(MAX_ORDER);

    // input opcodes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // reply kinds
    localparam logic REPLY_ALLOC = 1'b0;
    localparam logic REPLY_LIST  = 1'b1;

    // one entry of the unit memory
    typedef struct packed {
        logic                start;
        logic [ORDER_W-1:0]  order;
        logic [NAME_W-1:0]   owner;
    } t_unit_word;

    localparam int WORD_W = $bits(t_unit_word);

    // memory access request from the controller
    typedef struct packed {
        logic               we;
        logic [ADDR_W-1:0]  waddr;
        t_unit_word         wdata;
        logic               re;
        logic [ADDR_W-1:0]  raddr;
    } t_ram_req;

    // one result beat
    typedef struct packed {
        logic               valid;
        logic               reply_kind;
        logic               fit_ok;
        logic [CNT_W-1:0]   block_total;
        logic [NAME_W-1:0]  block_owner;
        logic               last_of_run;
    } t_result;

    // controller states
    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCAN,
        ST_SPLIT
    } t_state;

endpackage

### rtl/core/bba_ram.sv
// generic single-write, single-read ram with registered read
`timescale 1ns / 1ps

module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/bba_ctrl.sv
// scan and split sequencer working on the unit memory
`timescale 1ns / 1ps

module bba_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic                           i_opcode,
    input  logic [bba_pkg::NAME_W-1:0]     i_owner_name,
    input  logic [bba_pkg::SIZE_W-1:0]     i_request_size,
    input  logic                           i_cfg_write,
    input  logic [bba_pkg::ORDER_W-1:0]    i_eff_order,
    input  logic [bba_pkg::CNT_W-1:0]      i_pool_size,
    input  bba_pkg::t_unit_word            i_rdata,
    output logic                           o_busy,
    output bba_pkg::t_ram_req              o_ram,
    output bba_pkg::t_result               o_result
);

    bba_pkg::t_state                 r_state, n_state;
    logic [bba_pkg::CNT_W-1:0]       r_u, n_u;
    logic [bba_pkg::ORDER_W-1:0]     r_o, n_o;
    logic                            r_op, n_op;
    logic [bba_pkg::NAME_W-1:0]      r_name, n_name;
    logic [bba_pkg::SIZE_W-1:0]      r_req, n_req;
    logic [bba_pkg::CNT_W-1:0]       r_count, n_count;

    logic [bba_pkg::CNT_W-1:0]       len;
    logic [bba_pkg::CNT_W-1:0]       next_u;
    logic                            at_end;
    logic                            fits;
    logic [bba_pkg::CNT_W-1:0]       half;
    logic                            can_split;
    logic [bba_pkg::CNT_W-1:0]       buddy;

    // block length and next start of the block being looked at
    assign len    = i_rdata.start ? (bba_pkg::CNT_W'(1) << i_rdata.order)
                                  : bba_pkg::CNT_W'(1);
    assign next_u = r_u + len;
    assign at_end = (next_u >= i_pool_size);
    assign fits   = (i_rdata.owner == '0) && (bba_pkg::SIZE_W'(len) >= r_req)
                    && i_rdata.start;

    // halving test on the kept piece
    assign half      = bba_pkg::CNT_W'(1) << (r_o - bba_pkg::ORDER_W'(1));
    assign can_split = (r_o != '0) && (bba_pkg::SIZE_W'(half) >= r_req);
    assign buddy     = r_u + half;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bba_pkg::ST_INIT: begin
                n_state = bba_pkg::ST_IDLE;
            end
            bba_pkg::ST_IDLE: begin
                if (i_cfg_write) begin
                    n_state = bba_pkg::ST_INIT;
                end else if (i_start) begin
                    if (i_opcode == bba_pkg::OP_ALLOC && i_request_size == '0) begin
                        n_state = bba_pkg::ST_IDLE;
                    end else begin
                        n_state = bba_pkg::ST_SCAN;
                    end
                end
            end
            bba_pkg::ST_SCAN: begin
                if (r_op == bba_pkg::OP_QUERY) begin
                    if (at_end) begin
                        n_state = bba_pkg::ST_IDLE;
                    end
                end else if (fits) begin
                    n_state = bba_pkg::ST_SPLIT;
                end else if (at_end) begin
                    n_state = bba_pkg::ST_IDLE;
                end
            end
            bba_pkg::ST_SPLIT: begin
                if (!can_split) begin
                    n_state = bba_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bba_pkg::ST_INIT;
            end
        endcase
    end

    // datapath, memory requests and result beats
    always_comb begin
        n_u      = r_u;
        n_o      = r_o;
        n_op     = r_op;
        n_name   = r_name;
        n_req    = r_req;
        n_count  = r_count;
        o_ram    = '0;
        o_result = '0;
        o_result.block_total = r_count;
        case (r_state)
            bba_pkg::ST_INIT: begin
                // pool becomes one free block at unit zero
                o_ram.we          = 1'b1;
                o_ram.waddr       = '0;
                o_ram.wdata.start = 1'b1;
                o_ram.wdata.order = i_eff_order;
                o_ram.wdata.owner = '0;
                n_count           = bba_pkg::CNT_W'(1);
            end
            bba_pkg::ST_IDLE: begin
                if (!i_cfg_write && i_start) begin
                    n_op   = i_opcode;
                    n_name = i_owner_name;
                    n_req  = i_request_size;
                    n_u    = '0;
                    if (i_opcode == bba_pkg::OP_ALLOC && i_request_size == '0) begin
                        // zero size fails at once
                        o_result.valid       = 1'b1;
                        o_result.reply_kind  = bba_pkg::REPLY_ALLOC;
                        o_result.last_of_run = 1'b1;
                    end else begin
                        o_ram.re    = 1'b1;
                        o_ram.raddr = '0;
                    end
                end
            end
            bba_pkg::ST_SCAN: begin
                if (r_op == bba_pkg::OP_QUERY) begin
                    // one listing beat per block
                    o_result.valid       = 1'b1;
                    o_result.reply_kind  = bba_pkg::REPLY_LIST;
                    o_result.block_owner = i_rdata.owner;
                    o_result.last_of_run = at_end;
                    if (!at_end) begin
                        n_u         = next_u;
                        o_ram.re    = 1'b1;
                        o_ram.raddr = next_u[bba_pkg::ADDR_W-1:0];
                    end
                end else if (fits) begin
                    n_o = i_rdata.order;
                end else if (at_end) begin
                    // nothing fits
                    o_result.valid       = 1'b1;
                    o_result.reply_kind  = bba_pkg::REPLY_ALLOC;
                    o_result.last_of_run = 1'b1;
                end else begin
                    n_u         = next_u;
                    o_ram.re    = 1'b1;
                    o_ram.raddr = next_u[bba_pkg::ADDR_W-1:0];
                end
            end
            bba_pkg::ST_SPLIT: begin
                o_ram.we          = 1'b1;
                o_ram.wdata.start = 1'b1;
                if (can_split) begin
                    // new free buddy right after the kept half
                    o_ram.waddr       = buddy[bba_pkg::ADDR_W-1:0];
                    o_ram.wdata.order = r_o - bba_pkg::ORDER_W'(1);
                    o_ram.wdata.owner = '0;
                    n_o               = r_o - bba_pkg::ORDER_W'(1);
                    n_count           = r_count + bba_pkg::CNT_W'(1);
                end else begin
                    // claim the kept piece
                    o_ram.waddr          = r_u[bba_pkg::ADDR_W-1:0];
                    o_ram.wdata.order    = r_o;
                    o_ram.wdata.owner    = r_name;
                    o_result.valid       = 1'b1;
                    o_result.reply_kind  = bba_pkg::REPLY_ALLOC;
                    o_result.fit_ok      = 1'b1;
                    o_result.block_owner = r_name;
                    o_result.last_of_run = 1'b1;
                end
            end
            default: begin
                n_u = r_u;
            end
        endcase
    end

    assign o_busy = (r_state != bba_pkg::ST_IDLE);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bba_pkg::ST_INIT;
            r_count <= bba_pkg::CNT_W'(1);
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // item registers
    always_ff @(posedge i_clk) begin
        r_u    <= n_u;
        r_o    <= n_o;
        r_op   <= n_op;
        r_name <= n_name;
        r_req  <= n_req;
    end

endmodule

### rtl/core/buddy_block_allocator.sv
// top level of the buddy block allocator
`timescale 1ns / 1ps

// Buddy allocator over a pool of 2^total_order units (at most 64), blocks kept
// in address order in a 64-entry unit memory (start mark, order, owner).
// Command channel: an item is taken on a rising edge with start high and busy
// low. opcode 0 allocates request_size units for owner_name, opcode 1 lists
// every block. Results leave as one-cycle beats marked by o_result_valid; the
// receiver cannot stall them. An allocation gives one beat; a query gives one
// beat per block, the last one flagged by o_last_of_run.
// Timing: the scan reads one block start per cycle from the memory, and a query
// streams its beats one per cycle. A zero-size allocation answers in the cycle
// after the command.
// Configuration: total_order is written over i_cfg_valid / o_cfg_ready while
// idle and no command is offered; the write and reset both pass through the init
// state that rewrites unit zero, during which busy is high. Reset leaves
// total_order at 6 and one free block.
module buddy_block_allocator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_opcode,
    input  logic [bba_pkg::NAME_W-1:0]    i_owner_name,
    input  logic [bba_pkg::SIZE_W-1:0]    i_request_size,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bba_pkg::ORDER_W-1:0]   i_cfg_data,
    output logic                          o_result_valid,
    output logic                          o_reply_kind,
    output logic                          o_fit_ok,
    output logic [bba_pkg::CNT_W-1:0]     o_block_total,
    output logic [bba_pkg::NAME_W-1:0]    o_block_owner,
    output logic                          o_last_of_run
);

    logic [bba_pkg::ORDER_W-1:0] r_total_order;
    logic [bba_pkg::ORDER_W-1:0] eff_order;
    logic [bba_pkg::CNT_W-1:0]   pool_size;
    logic                        cfg_write;
    logic                        ctrl_busy;
    bba_pkg::t_ram_req           ram_req;
    bba_pkg::t_result            result;
    logic [bba_pkg::WORD_W-1:0]  rdata_bits;
    bba_pkg::t_unit_word         rdata;
    logic                        r_valid;
    logic                        r_reply_kind;
    logic                        r_fit_ok;
    logic [bba_pkg::CNT_W-1:0]   r_block_total;
    logic [bba_pkg::NAME_W-1:0]  r_block_owner;
    logic                        r_last_of_run;

    // order register, clamped to the largest pool; a command beat wins over a write
    assign o_cfg_ready = !ctrl_busy && !start;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;
    assign eff_order   = (r_total_order > bba_pkg::ORDER_W'(bba_pkg::MAX_ORDER))
                         ? bba_pkg::ORDER_W'(bba_pkg::MAX_ORDER) : r_total_order;
    assign pool_size   = bba_pkg::CNT_W'(1) << eff_order;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_order <= bba_pkg::TOTAL_ORDER_RESET;
        end else if (cfg_write) begin
            r_total_order <= i_cfg_data;
        end
    end

    // unit memory
    bba_ram #(
        .WIDTH (bba_pkg::WORD_W),
        .DEPTH (bba_pkg::POOL_UNITS)
    ) u_unit_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (rdata_bits)
    );

    assign rdata = bba_pkg::t_unit_word'(rdata_bits);

    // scan and split sequencer
    bba_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_opcode       (i_opcode),
        .i_owner_name   (i_owner_name),
        .i_request_size (i_request_size),
        .i_cfg_write    (cfg_write),
        .i_eff_order    (eff_order),
        .i_pool_size    (pool_size),
        .i_rdata        (rdata),
        .o_busy         (ctrl_busy),
        .o_ram          (ram_req),
        .o_result       (result)
    );

    assign busy = ctrl_busy;

    // result beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_reply_kind  <= result.reply_kind;
        r_fit_ok      <= result.fit_ok;
        r_block_total <= result.block_total;
        r_block_owner <= result.block_owner;
        r_last_of_run <= result.last_of_run;
    end

    assign o_result_valid = r_valid;
    assign o_reply_kind   = r_reply_kind;
    assign o_fit_ok       = r_fit_ok;
    assign o_block_total  = r_block_total;
    assign o_block_owner  = r_block_owner;
    assign o_last_of_run  = r_last_of_run;

endmodule

### tb/sv/buddy_block_allocator_test.sv
// self-checking testbench of the buddy block allocator
`timescale 1ns / 1ps

module buddy_block_allocator_test;

    // one result beat as the checker sees it
    typedef struct packed {
        logic                        kind;
        logic                        fit;
        logic [bba_pkg::CNT_W-1:0]   total;
        logic [bba_pkg::NAME_W-1:0]  owner;
        logic                        last;
    } t_reply;

    // one command, with an optional order write ahead of it and an optional typed reply
    typedef struct packed {
        logic                        do_cfg;
        logic [bba_pkg::ORDER_W-1:0] cfg_val;
        logic                        op;
        logic [bba_pkg::NAME_W-1:0]  name;
        logic [bba_pkg::SIZE_W-1:0]  size;
        logic                        typed;
        logic                        fit;
        logic [bba_pkg::CNT_W-1:0]   total;
        logic [bba_pkg::NAME_W-1:0]  owner;
    } t_row;

    localparam int N_ROWS       = 24;
    localparam int RAND_PHASES  = 6;
    localparam int PHASE_ITEMS  = 16;
    localparam int SHOWN_ERRORS = 10;

    // directed commands; replies typed only where they are obvious
    localparam t_row DIRECTED_ROWS [N_ROWS] = '{
        // fresh pool after reset
        '{1'b0, 3'd0, bba_pkg::OP_QUERY, 16'h0000, 7'd0,   1'b0, 1'b0, 7'd0, 16'h0000},
        '{1'b0, 3'd0, bba_pkg::OP_ALLOC, 16'h1234, 7'd0,   1'b1, 1'b0, 7'd1, 16'h0000},
        '{1'b0, 3'd0, bba_pkg::OP_ALLOC, 16'hFFFF, 7'd127, 1'b1, 1'b0, 7'd1, 16'h0000},
        '{1'b0, 3'd0, bba_pkg::OP_ALLOC, 16'hFFFF, 7'd64,  1'b1, 1'b1, 7'd1, 16'hFFFF},
        '{1'b0, 3'd0, bba_pkg::OP_ALLOC, 16'h0001, 7'd1,   1'b1, 1'b0, 7'd1, 16'h0000},
        '{1'b0, 3'd0, bba_pkg::OP_QUERY, 16'h0000, 7'd0,   1'b0, 1'b0, 7'd0, 16'h0000},
        // full split down to one unit, then a free-named block and a kept size
        '{1'b1, 3'd6, bba_pkg::OP_ALLOC, 16'h0001, 7'd1,   1'b1, 1'b1, 7'd7, 16'h0001},
        '{1'b0, 3'd0, bba_pkg::OP_ALLOC, 16'h0000, 7'd3,   1'b1, 1'b1, 7'd7, 16'h0000},
        '{1'b0, 3'd0, bba_pkg::OP_ALLOC, 16'hABCD, 7'd3,   1'b1, 1'b1, 7'd7, 16'hABCD},
        '{1'b0, 3'd0, bba_pkg::OP_ALLOC, 16'h5555, 7'd33,  1'b1, 1'b0, 7'd7, 16'h0000},
        '{1'b0, 3'd0, bba_pkg::OP_ALLOC, 16'hAAAA, 7'd17,  1'b1, 1'b1, 7'd7, 16'hAAAA},
        '{1'b0, 3'd0, bba_pkg::OP_QUERY, 16'hFFFF, 7'd127, 1'b0, 1'b0, 7'd0, 16'h0000},
        // order above the maximum acts as the maximum
        '{1'b1, 3'd7, bba_pkg::OP_QUERY, 16'h0000, 7'd0,   1'b0, 1'b0, 7'd0, 16'h0000},
        '{1'b0, 3'd0, bba_pkg::OP_ALLOC, 16'h00FF, 7'd2,   1'b1, 1'b1, 7'd6, 16'h00FF},
        // single-unit pool
        '{1'b1, 3'd0, bba_pkg::OP_ALLOC, 16'h0F0F, 7'd1,   1'b1, 1'b1, 7'd1, 16'h0F0F},
        '{1'b0, 3'd0, bba_pkg::OP_QUERY, 16'h0000, 7'd0,   1'b0, 1'b0, 7'd0, 16'h0000},
        '{1'b0, 3'd0, bba_pkg::OP_ALLOC, 16'h0001, 7'd1,   1'b1, 1'b0, 7'd1, 16'h0000},
        // small pools
        '{1'b1, 3'd1, bba_pkg::OP_ALLOC, 16'h8000, 7'd2,   1'b1, 1'b1, 7'd1, 16'h8000},
        '{1'b1, 3'd3, bba_pkg::OP_ALLOC, 16'h7FFF, 7'd1,   1'b1, 1'b1, 7'd4, 16'h7FFF},
        '{1'b0, 3'd0, bba_pkg::OP_ALLOC, 16'h4000, 7'd1,   1'b1, 1'b1, 7'd4, 16'h4000},
        '{1'b0, 3'd0, bba_pkg::OP_QUERY, 16'h0000, 7'd0,   1'b0, 1'b0, 7'd0, 16'h0000},
        '{1'b1, 3'd5, bba_pkg::OP_ALLOC, 16'h2000, 7'd32,  1'b1, 1'b1, 7'd1, 16'h2000},
        '{1'b0, 3'd0, bba_pkg::OP_QUERY, 16'h0000, 7'd0,   1'b0, 1'b0, 7'd0, 16'h0000},
        '{1'b0, 3'd0, bba_pkg::OP_ALLOC, 16'h5A5A, 7'd1,   1'b0, 1'b0, 7'd0, 16'h0000}
    };

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        start_cmd = 1'b0;
    logic                        busy;
    logic                        opcode = bba_pkg::OP_ALLOC;
    logic [bba_pkg::NAME_W-1:0]  owner_name = '0;
    logic [bba_pkg::SIZE_W-1:0]  request_size = '0;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [bba_pkg::ORDER_W-1:0] cfg_data = '0;
    logic                        result_valid;
    logic                        reply_kind;
    logic                        fit_ok;
    logic [bba_pkg::CNT_W-1:0]   block_total;
    logic [bba_pkg::NAME_W-1:0]  block_owner;
    logic                        last_of_run;

    // pool image kept by the predictor
    logic                        pool_start [bba_pkg::POOL_UNITS];
    logic [bba_pkg::ORDER_W-1:0] pool_order [bba_pkg::POOL_UNITS];
    logic [bba_pkg::NAME_W-1:0]  pool_owner [bba_pkg::POOL_UNITS];
    logic [bba_pkg::CNT_W-1:0]   pool_blocks;
    logic [bba_pkg::ORDER_W-1:0] order_reg;

    t_reply awaited_replies [$];
    int     mismatch_count = 0;

    buddy_block_allocator i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .start          (start_cmd),
        .busy           (busy),
        .i_opcode       (opcode),
        .i_owner_name   (owner_name),
        .i_request_size (request_size),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data),
        .o_result_valid (result_valid),
        .o_reply_kind   (reply_kind),
        .o_fit_ok       (fit_ok),
        .o_block_total  (block_total),
        .o_block_owner  (block_owner),
        .o_last_of_run  (last_of_run)
    );

    // 10 ns clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // order actually used, clamped to the maximum
    function automatic int pool_order_used();
        return (order_reg > bba_pkg::MAX_ORDER) ? bba_pkg::MAX_ORDER : int'(order_reg);
    endfunction

    // back to one free block spanning the pool
    function automatic void clear_pool();
        for (int u = 0; u < bba_pkg::POOL_UNITS; u++) begin
            pool_start[u] = 1'b0;
            pool_order[u] = '0;
            pool_owner[u] = '0;
        end
        pool_start[0] = 1'b1;
        pool_order[0] = bba_pkg::ORDER_W'(pool_order_used());
        pool_blocks   = bba_pkg::CNT_W'(1);
    endfunction

    function automatic int block_len(input int u);
        return pool_start[u] ? (1 << pool_order[u]) : 1;
    endfunction

    // first fit in address order, halving while the half still holds the request
    function automatic logic carve_block(input logic [bba_pkg::NAME_W-1:0] name,
                                         input logic [bba_pkg::SIZE_W-1:0] size);
        int span;
        int req;
        int u;
        int o;
        span = 1 << pool_order_used();
        req  = int'(size);
        u    = 0;
        if (req == 0)
            return 1'b0;
        while (u < span) begin
            if (pool_start[u] && pool_owner[u] == '0 && block_len(u) >= req) begin
                o = int'(pool_order[u]);
                while (o > 0 && ((1 << o) >> 1) >= req) begin
                    o--;
                    pool_start[u + (1 << o)] = 1'b1;
                    pool_order[u + (1 << o)] = bba_pkg::ORDER_W'(o);
                    pool_owner[u + (1 << o)] = '0;
                    pool_blocks = pool_blocks + 1'b1;
                end
                pool_order[u] = bba_pkg::ORDER_W'(o);
                pool_owner[u] = name;
                return 1'b1;
            end
            u += block_len(u);
        end
        return 1'b0;
    endfunction

    // replies that one accepted command must produce
    function automatic void predict_replies(input t_row r);
        logic ok;
        int   span;
        int   u;
        if (r.op == bba_pkg::OP_ALLOC) begin
            ok = carve_block(r.name, r.size);
            awaited_replies.push_back('{bba_pkg::REPLY_ALLOC, ok, pool_blocks,
                                        ok ? r.name : '0, 1'b1});
        end else begin
            span = 1 << pool_order_used();
            u    = 0;
            while (u < span) begin
                awaited_replies.push_back('{bba_pkg::REPLY_LIST, 1'b0, pool_blocks,
                                            pool_owner[u], (u + block_len(u) >= span)});
                u += block_len(u);
            end
        end
    endfunction

    function automatic void note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= SHOWN_ERRORS)
            $display("mismatch at %0t: %s", $realtime, msg);
    endfunction

    // drive one command and hold it until the block takes it
    task automatic send_row(input t_row r);
        @(negedge clk);
        start_cmd    <= 1'b1;
        opcode       <= r.op;
        owner_name   <= r.name;
        request_size <= r.size;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (r.typed) begin
            void'(carve_block(r.name, r.size));
            awaited_replies.push_back('{bba_pkg::REPLY_ALLOC, r.fit, r.total, r.owner, 1'b1});
        end else begin
            predict_replies(r);
        end
    endtask

    // idle cycles after a command; zero keeps start high into the next one
    task automatic idle_cycles(input int gap);
        if (gap > 0) begin
            @(negedge clk);
            start_cmd <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // stop sending and let every awaited reply come out
    task automatic drain_replies();
        @(negedge clk);
        start_cmd <= 1'b0;
        while (awaited_replies.size() != 0)
            @(posedge clk);
        repeat (6) @(negedge clk);
    endtask

    // order register write while the block is idle
    task automatic write_order(input logic [bba_pkg::ORDER_W-1:0] value);
        drain_replies();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        order_reg = value;
        clear_pool();
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // check every result beat against the oldest awaited reply
    always @(posedge clk) begin : beat_check
        t_reply want;
        if (rst_n && result_valid) begin
            if (awaited_replies.size() == 0) begin
                note_mismatch($sformatf(
                    "unawaited beat kind %0d fit %0d total %0d owner %h last %0d",
                    reply_kind, fit_ok, block_total, block_owner, last_of_run));
            end else begin
                want = awaited_replies.pop_front();
                if (reply_kind !== want.kind || fit_ok !== want.fit ||
                    block_total !== want.total || block_owner !== want.owner ||
                    last_of_run !== want.last)
                    note_mismatch($sformatf(
                        {"got kind %0d fit %0d total %0d owner %h last %0d,",
                         " want kind %0d fit %0d total %0d owner %h last %0d"},
                        reply_kind, fit_ok, block_total, block_owner,
                        last_of_run, want.kind, want.fit, want.total,
                        want.owner, want.last));
            end
        end
    end

    // stimulus
    initial begin
        t_row                        r;
        int                          span;
        int                          shift;
        logic                        no_gaps;
        logic [bba_pkg::ORDER_W-1:0] value;
        order_reg = bba_pkg::TOTAL_ORDER_RESET;
        clear_pool();
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // directed table
        for (int i = 0; i < N_ROWS; i++) begin
            if (DIRECTED_ROWS[i].do_cfg)
                write_order(DIRECTED_ROWS[i].cfg_val);
            send_row(DIRECTED_ROWS[i]);
            idle_cycles($urandom_range(0, 15));
        end

        // random phases, each on a freshly written pool
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case ($urandom_range(0, 7))
                0, 1, 2: value = 3'd6;
                3, 4:    value = 3'd7;
                5:       value = 3'd5;
                default: value = bba_pkg::ORDER_W'($urandom_range(0, 4));
            endcase
            write_order(value);
            no_gaps = ($urandom_range(0, 3) == 0);
            span    = 1 << pool_order_used();
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                r       = '0;
                r.op    = ($urandom_range(0, 4) == 0) ? bba_pkg::OP_QUERY : bba_pkg::OP_ALLOC;
                r.name  = ($urandom_range(0, 9) == 0) ? '0 :
                          bba_pkg::NAME_W'($urandom_range(0, 65535));
                case ($urandom_range(0, 15))
                    0:       r.size = '0;
                    1:       r.size = bba_pkg::SIZE_W'($urandom_range(0, 127));
                    default: begin
                        shift  = $urandom_range(0, 3);
                        r.size = bba_pkg::SIZE_W'($urandom_range(1, ((span >> shift) > 0) ?
                                                                    (span >> shift) : 1));
                    end
                endcase
                send_row(r);
                if ($urandom_range(0, 31) == 0)
                    drain_replies();
                else
                    idle_cycles(no_gaps ? 0 : $urandom_range(0, 15));
            end
        end

        // wait for the tail of the replies
        @(negedge clk);
        start_cmd <= 1'b0;
        while (awaited_replies.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && awaited_replies.size() == 0)
            $display("buddy_block_allocator_test: clean");
        else
            $display("buddy_block_allocator_test: errors");
        $finish;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("buddy_block_allocator_test: errors");
        $finish;
    end

endmodule

### buddy_block_allocator.f
rtl/core/bba_pkg.sv
rtl/core/bba_ram.sv
rtl/core/bba_ctrl.sv
rtl/core/buddy_block_allocator.sv
tb/sv/buddy_block_allocator_test.sv
